### rtl/core/modbus_tcp_register_server_defines.svh
// assertion macros for the modbus tcp register server
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef MODBUS_TCP_REGISTER_SERVER_DEFINES_SVH
`define MODBUS_TCP_REGISTER_SERVER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MTRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtrs assertion failed");
`define MTRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtrs assertion failed");
`else
`define MTRS_ASSERT_NOW(label, ante, cons)
`define MTRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/mtrs_pkg.sv
// shared types and constants for the modbus tcp register server
// no dependencies
package mtrs_pkg;

    localparam int FRAME_BYTES_DEF    = 128;
    localparam int REG_COUNT_DEF      = 64;
    localparam int MAX_READ_WORDS_DEF = 27;

    localparam int READ_HEAD_BYTES = 9;
    localparam int ECHO_BYTES      = 12;
    localparam int WRITE_DATA_AT   = 13;
    localparam int MIN_FN_BYTES    = 8;
    localparam int FN_AT           = 7;
    localparam int START_HI_AT     = 8;
    localparam int START_LO_AT     = 9;
    localparam int NUM_HI_AT       = 10;
    localparam int NUM_LO_AT       = 11;
    localparam int LEN_HI_AT       = 4;
    localparam int LEN_LO_AT       = 5;
    localparam int BYTE_COUNT_AT   = 8;
    localparam int WRITE_REPLY_LEN = 6;

    localparam logic [7:0] FN_READ_HOLD   = 8'd3;
    localparam logic [7:0] FN_READ_INPUT  = 8'd4;
    localparam logic [7:0] FN_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FN_WRITE_HOLD  = 8'd6;
    localparam logic [7:0] FN_WRITE_MULTI = 8'd16;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_FUNC  = 2'd1,
        ST_BAD_RANGE = 2'd2,
        ST_SHORT     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WR_HI,
        S_WR_LO,
        S_WR_DO,
        S_SEND_ADDR,
        S_SEND_LOAD,
        S_SEND_WAIT
    } state_t;

endpackage

### rtl/core/modbus_tcp_register_server.sv
// Modbus TCP register server: request bytes are taken one per cycle while idle; the
// mode 0 transaction carrying frame_end starts decode and the block stalls its input until
// the last response transaction is taken. A response passes through a decode state, for
// function 16 two frame memory reads and a store write per word, and per response byte
// a memory read, an output load and a handoff, plus any output stall. Input register
// loads (mode 1) are written into the input register store when accepted.
// depends on mtrs_pkg and modbus_tcp_register_server_defines.svh
`include "modbus_tcp_register_server_defines.svh"

module modbus_tcp_register_server
    import mtrs_pkg::*;
#(
    parameter int FRAME_BYTES    = FRAME_BYTES_DEF,
    parameter int REG_COUNT      = REG_COUNT_DEF,
    parameter int MAX_READ_WORDS = MAX_READ_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    input  logic [5:0]  load_index,
    input  logic [15:0] load_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic [1:0]  status
);

    localparam int FA_W  = $clog2(FRAME_BYTES);
    localparam int FL_W  = $clog2(FRAME_BYTES + 1);
    localparam int REG_W = $clog2(REG_COUNT);

    state_t state_reg, state_next;

    logic [FL_W-1:0]  fill_reg, fill_next;
    logic [FL_W-1:0]  len_reg, len_next;
    logic [7:0]       fn_reg, fn_next;
    logic [15:0]      start_reg, start_next;
    logic [15:0]      num_reg, num_next;
    logic             is_read_reg, is_read_next;
    logic [5:0]       k_reg, k_next;
    logic [15:0]      widx_reg, widx_next;
    logic [7:0]       hi_reg, hi_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       tx_byte_reg, tx_byte_next;
    logic             last_reg, last_next;
    logic [1:0]       status_reg, status_next;

    logic [7:0]       frame_mem [FRAME_BYTES];
    logic [15:0]      holding_mem [REG_COUNT];
    logic [15:0]      input_mem [REG_COUNT];
    logic [15:0]      coil_mem [REG_COUNT];
    logic [REG_COUNT-1:0] holding_valid_reg;
    logic [REG_COUNT-1:0] input_valid_reg;

    logic [7:0]       frame_rdata_reg;
    logic [15:0]      hold_rdata_reg;
    logic [15:0]      inp_rdata_reg;
    logic             hold_vld_rd_reg;
    logic             inp_vld_rd_reg;

    logic             in_accept;
    logic             out_accept;
    logic             fill_room;
    logic [FL_W-1:0]  fill_grow;
    logic             frame_we;
    logic [FA_W-1:0]  frame_waddr;
    logic [17:0]      frame_raddr_wide;
    logic [FA_W-1:0]  frame_raddr;
    logic [5:0]       rel;
    logic [REG_W-1:0] reg_raddr;
    logic             hold_we;
    logic [REG_W-1:0] hold_waddr;
    logic [15:0]      hold_wdata;
    logic             coil_we;
    logic             inp_we;
    logic [REG_W-1:0] inp_waddr;
    logic [17:0]      len18;
    logic [16:0]      range_sum;
    logic [16:0]      reg_limit;
    logic             fn_ok;
    status_t          dec_status;
    logic [5:0]       total_bytes;
    logic [15:0]      reg_word;
    logic [7:0]       twice_num;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_valid  = out_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign last       = last_reg;
    assign status     = status_reg;

    assign fill_room = (fill_reg < FL_W'(FRAME_BYTES));
    assign fill_grow = fill_reg + FL_W'(fill_room);

    // decode checks
    assign len18     = 18'(len_reg);
    assign range_sum = {1'b0, start_reg} + {1'b0, num_reg};
    assign reg_limit = 17'(REG_COUNT);
    assign fn_ok     = (fn_reg == FN_READ_HOLD) || (fn_reg == FN_READ_INPUT)
                    || (fn_reg == FN_WRITE_COIL) || (fn_reg == FN_WRITE_HOLD)
                    || (fn_reg == FN_WRITE_MULTI);

    always_comb
    begin
        dec_status = ST_OK;
        if (len18 < 18'(MIN_FN_BYTES))
        begin
            dec_status = ST_SHORT;
        end
        else if (!fn_ok)
        begin
            dec_status = ST_BAD_FUNC;
        end
        else if (len18 < 18'(ECHO_BYTES))
        begin
            dec_status = ST_SHORT;
        end
        else if ((fn_reg == FN_READ_HOLD) || (fn_reg == FN_READ_INPUT))
        begin
            if ((num_reg == 16'd0) || (num_reg > 16'(MAX_READ_WORDS))
                || (range_sum > reg_limit))
            begin
                dec_status = ST_BAD_RANGE;
            end
        end
        else if (fn_reg == FN_WRITE_MULTI)
        begin
            if ((num_reg == 16'd0) || (range_sum > reg_limit))
            begin
                dec_status = ST_BAD_RANGE;
            end
            else if (len18 < (18'(WRITE_DATA_AT) + {1'b0, num_reg, 1'b0}))
            begin
                dec_status = ST_SHORT;
            end
        end
        else if ({1'b0, start_reg} >= reg_limit)
        begin
            dec_status = ST_BAD_RANGE;
        end
    end

    assign twice_num   = {num_reg[6:0], 1'b0};
    assign total_bytes = is_read_reg ? (6'(READ_HEAD_BYTES) + {num_reg[4:0], 1'b0})
                                     : 6'(ECHO_BYTES);

    // memory addressing
    always_comb
    begin
        unique case (state_reg)
            S_WR_HI: frame_raddr_wide = 18'(WRITE_DATA_AT) + {1'b0, widx_reg, 1'b0};
            S_WR_LO: frame_raddr_wide = 18'(WRITE_DATA_AT) + {1'b0, widx_reg, 1'b0} + 18'd1;
            default: frame_raddr_wide = 18'(k_reg);
        endcase
    end
    assign frame_raddr = frame_raddr_wide[FA_W-1:0];
    assign frame_we    = in_accept && !mode && fill_room;
    assign frame_waddr = fill_reg[FA_W-1:0];

    assign rel       = k_reg - 6'(READ_HEAD_BYTES);
    assign reg_raddr = start_reg[REG_W-1:0] + REG_W'(rel[5:1]);

    always_comb
    begin
        hold_we    = 1'b0;
        hold_waddr = start_reg[REG_W-1:0];
        hold_wdata = num_reg;
        if (state_reg == S_WR_DO)
        begin
            hold_we    = 1'b1;
            hold_waddr = start_reg[REG_W-1:0] + widx_reg[REG_W-1:0];
            hold_wdata = {hi_reg, frame_rdata_reg};
        end
        else if ((state_reg == S_DECODE) && (dec_status == ST_OK)
                 && (fn_reg == FN_WRITE_HOLD))
        begin
            hold_we = 1'b1;
        end
    end

    assign coil_we   = (state_reg == S_DECODE) && (dec_status == ST_OK)
                    && (fn_reg == FN_WRITE_COIL);
    assign inp_we    = in_accept && mode && (7'(load_index) < 7'(REG_COUNT > 64 ? 64 : REG_COUNT));
    assign inp_waddr = REG_W'(load_index);

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= rx_byte;
        end
        frame_rdata_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hold_we)
        begin
            holding_mem[hold_waddr] <= hold_wdata;
        end
        hold_rdata_reg <= holding_mem[reg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (inp_we)
        begin
            input_mem[inp_waddr] <= load_value;
        end
        inp_rdata_reg <= input_mem[reg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (coil_we)
        begin
            coil_mem[start_reg[REG_W-1:0]] <= num_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_valid_reg <= '0;
            input_valid_reg   <= '0;
            hold_vld_rd_reg   <= 1'b0;
            inp_vld_rd_reg    <= 1'b0;
        end
        else
        begin
            if (hold_we)
            begin
                holding_valid_reg[hold_waddr] <= 1'b1;
            end
            if (inp_we)
            begin
                input_valid_reg[inp_waddr] <= 1'b1;
            end
            hold_vld_rd_reg <= holding_valid_reg[reg_raddr];
            inp_vld_rd_reg  <= input_valid_reg[reg_raddr];
        end
    end

    assign reg_word = (fn_reg == FN_READ_HOLD)
                    ? (hold_vld_rd_reg ? hold_rdata_reg : 16'd0)
                    : (inp_vld_rd_reg ? inp_rdata_reg : 16'd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && !mode && frame_end)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (dec_status != ST_OK)
                begin
                    state_next = S_SEND_WAIT;
                end
                else if (fn_reg == FN_WRITE_MULTI)
                begin
                    state_next = S_WR_HI;
                end
                else
                begin
                    state_next = S_SEND_ADDR;
                end
            end
            S_WR_HI:     state_next = S_WR_LO;
            S_WR_LO:     state_next = S_WR_DO;
            S_WR_DO:
            begin
                if (widx_reg == (num_reg - 16'd1))
                begin
                    state_next = S_SEND_ADDR;
                end
                else
                begin
                    state_next = S_WR_HI;
                end
            end
            S_SEND_ADDR: state_next = S_SEND_LOAD;
            S_SEND_LOAD: state_next = S_SEND_WAIT;
            S_SEND_WAIT:
            begin
                if (out_accept)
                begin
                    state_next = last_reg ? S_IDLE : S_SEND_ADDR;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        fill_next      = fill_reg;
        len_next       = len_reg;
        fn_next        = fn_reg;
        start_next     = start_reg;
        num_next       = num_reg;
        is_read_next   = is_read_reg;
        k_next         = k_reg;
        widx_next      = widx_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg;
        tx_byte_next   = tx_byte_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && !mode)
                begin
                    if (fill_room)
                    begin
                        case (fill_reg)
                            FL_W'(FN_AT):       fn_next          = rx_byte;
                            FL_W'(START_HI_AT): start_next[15:8] = rx_byte;
                            FL_W'(START_LO_AT): start_next[7:0]  = rx_byte;
                            FL_W'(NUM_HI_AT):   num_next[15:8]   = rx_byte;
                            FL_W'(NUM_LO_AT):   num_next[7:0]    = rx_byte;
                            default:            fn_next          = fn_reg;
                        endcase
                    end
                    if (frame_end)
                    begin
                        len_next  = fill_grow;
                        fill_next = '0;
                    end
                    else
                    begin
                        fill_next = fill_grow;
                    end
                end
            end
            S_DECODE:
            begin
                k_next       = '0;
                widx_next    = '0;
                is_read_next = (fn_reg == FN_READ_HOLD) || (fn_reg == FN_READ_INPUT);
                if (dec_status != ST_OK)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = 8'd0;
                    last_next      = 1'b1;
                    status_next    = dec_status;
                end
            end
            S_WR_HI:
            begin
            end
            S_WR_LO:
            begin
                hi_next = frame_rdata_reg;
            end
            S_WR_DO:
            begin
                widx_next = widx_reg + 16'd1;
            end
            S_SEND_ADDR:
            begin
            end
            S_SEND_LOAD:
            begin
                out_valid_next = 1'b1;
                last_next      = (k_reg == (total_bytes - 6'd1));
                status_next    = ST_OK;
                tx_byte_next   = frame_rdata_reg;
                if (k_reg == 6'(LEN_HI_AT))
                begin
                    tx_byte_next = 8'd0;
                end
                else if (k_reg == 6'(LEN_LO_AT))
                begin
                    tx_byte_next = is_read_reg ? (twice_num + 8'd3) : 8'(WRITE_REPLY_LEN);
                end
                else if (is_read_reg && (k_reg == 6'(BYTE_COUNT_AT)))
                begin
                    tx_byte_next = twice_num;
                end
                else if (is_read_reg && (k_reg >= 6'(READ_HEAD_BYTES)))
                begin
                    tx_byte_next = rel[0] ? reg_word[7:0] : reg_word[15:8];
                end
            end
            S_SEND_WAIT:
            begin
                if (out_accept)
                begin
                    out_valid_next = 1'b0;
                    k_next         = k_reg + 6'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            fn_reg        <= '0;
            start_reg     <= '0;
            num_reg       <= '0;
            is_read_reg   <= 1'b0;
            k_reg         <= '0;
            widx_reg      <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
            tx_byte_reg   <= '0;
            last_reg      <= 1'b0;
            status_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            fn_reg        <= fn_next;
            start_reg     <= start_next;
            num_reg       <= num_next;
            is_read_reg   <= is_read_next;
            k_reg         <= k_next;
            widx_reg      <= widx_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
            tx_byte_reg   <= tx_byte_next;
            last_reg      <= last_next;
            status_reg    <= status_next;
        end
    end

    `MTRS_ASSERT_NOW(a_ready_no_pending, !in_stall, !out_valid)
    `MTRS_ASSERT_NOW(a_status_is_single, out_valid && (status != ST_OK), last && (tx_byte == 8'd0))
    `MTRS_ASSERT_NEXT(a_frame_end_stalls, in_valid && !in_stall && !mode && frame_end, in_stall)
    `MTRS_ASSERT_NOW(a_byte_in_reply, out_valid && (status == ST_OK), k_reg < total_bytes)

endmodule

### tb/sv/testbench.sv
// testbench for modbus_tcp_register_server: request frames, register loads and random traffic
// checked against a built-in model of the register server; depends on mtrs_pkg and the rtl
module testbench;
    import mtrs_pkg::*;

    // small frame store so that overflow frames stay short
    localparam int FRAME_LIMIT = 32;

    typedef struct {
        logic [7:0] tx;
        logic       lst;
        status_t    st;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = 1'b0;
    logic [7:0]  rx_byte = 8'd0;
    logic        frame_end = 1'b0;
    logic [5:0]  load_index = 6'd0;
    logic [15:0] load_value = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;

    logic [7:0]  frame_mem [FRAME_LIMIT];
    int          frame_len;
    logic [15:0] hold_regs [REG_COUNT_DEF];
    logic [15:0] input_regs [REG_COUNT_DEF];
    logic [15:0] coil_regs [REG_COUNT_DEF];
    reply_t      reply_q [$];

    int errors;
    int send_idle;
    int recv_stall;
    int frames_sent;
    int items_sent;
    int replies_seen;

    modbus_tcp_register_server #(.FRAME_BYTES(FRAME_LIMIT)) dut (.*);

    always #6 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall);

    function automatic void push_reply(logic [7:0] b, logic l, status_t s);
        reply_t r;
        r.tx = b;
        r.lst = l;
        r.st = s;
        reply_q.push_back(r);
    endfunction

    function automatic logic [15:0] frame_word(int at);
        return {frame_mem[at], frame_mem[at + 1]};
    endfunction

    function automatic void serve_request(int len);
        logic [7:0] fn;
        logic [7:0] resp [64];
        int start;
        int num;
        int n;
        logic [15:0] w;
        if (len < MIN_FN_BYTES)
        begin
            push_reply(8'd0, 1'b1, ST_SHORT);
            return;
        end
        fn = frame_mem[FN_AT];
        if (fn != FN_READ_HOLD && fn != FN_READ_INPUT && fn != FN_WRITE_COIL &&
            fn != FN_WRITE_HOLD && fn != FN_WRITE_MULTI)
        begin
            push_reply(8'd0, 1'b1, ST_BAD_FUNC);
            return;
        end
        if (len < ECHO_BYTES)
        begin
            push_reply(8'd0, 1'b1, ST_SHORT);
            return;
        end
        start = frame_word(START_HI_AT);
        num = frame_word(NUM_HI_AT);
        for (int i = 0; i < ECHO_BYTES; i++)
            resp[i] = frame_mem[i];
        resp[LEN_HI_AT] = 8'd0;
        if (fn == FN_READ_HOLD || fn == FN_READ_INPUT)
        begin
            if (num == 0 || num > MAX_READ_WORDS_DEF || start + num > REG_COUNT_DEF)
            begin
                push_reply(8'd0, 1'b1, ST_BAD_RANGE);
                return;
            end
            resp[LEN_LO_AT] = 8'(2 * num + 3);
            resp[BYTE_COUNT_AT] = 8'(2 * num);
            for (int i = 0; i < num; i++)
            begin
                w = (fn == FN_READ_HOLD) ? hold_regs[start + i] : input_regs[start + i];
                resp[READ_HEAD_BYTES + 2 * i] = w[15:8];
                resp[READ_HEAD_BYTES + 2 * i + 1] = w[7:0];
            end
            n = READ_HEAD_BYTES + 2 * num;
        end
        else
        begin
            if (fn == FN_WRITE_MULTI)
            begin
                if (num == 0 || start + num > REG_COUNT_DEF)
                begin
                    push_reply(8'd0, 1'b1, ST_BAD_RANGE);
                    return;
                end
                if (len < WRITE_DATA_AT + 2 * num)
                begin
                    push_reply(8'd0, 1'b1, ST_SHORT);
                    return;
                end
                for (int i = 0; i < num; i++)
                    hold_regs[start + i] = frame_word(WRITE_DATA_AT + 2 * i);
            end
            else
            begin
                if (start >= REG_COUNT_DEF)
                begin
                    push_reply(8'd0, 1'b1, ST_BAD_RANGE);
                    return;
                end
                if (fn == FN_WRITE_COIL)
                    coil_regs[start] = 16'(num);
                else
                    hold_regs[start] = 16'(num);
            end
            resp[LEN_LO_AT] = 8'(WRITE_REPLY_LEN);
            n = ECHO_BYTES;
        end
        for (int i = 0; i < n; i++)
            push_reply(resp[i], i + 1 == n, ST_OK);
    endfunction

    function automatic void model_item(logic m, logic [7:0] b, logic fe, logic [5:0] ix,
                                       logic [15:0] v);
        int len;
        if (m)
        begin
            if (ix < REG_COUNT_DEF)
                input_regs[ix] = v;
            return;
        end
        if (frame_len < FRAME_LIMIT)
        begin
            frame_mem[frame_len] = b;
            frame_len++;
        end
        if (!fe)
            return;
        len = frame_len;
        frame_len = 0;
        serve_request(len);
    endfunction

    task automatic send_item(logic m, logic [7:0] b, logic fe, logic [5:0] ix, logic [15:0] v);
        @(negedge clk);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        mode <= m;
        rx_byte <= b;
        frame_end <= fe;
        load_index <= ix;
        load_value <= v;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        model_item(m, b, fe, ix, v);
        items_sent++;
    endtask

    task automatic send_frame(logic [7:0] bytes [$]);
        foreach (bytes[i])
            send_item(1'b0, bytes[i], i == bytes.size() - 1, 6'($urandom), 16'($urandom));
        frames_sent++;
    endtask

    task automatic load_input(logic [5:0] ix, logic [15:0] v);
        send_item(1'b1, 8'($urandom), 1'($urandom), ix, v);
    endtask

    function automatic void build_request(ref logic [7:0] f [$], input logic [7:0] fn,
                                          input logic [15:0] start, input logic [15:0] num);
        f = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), fn, start[15:8], start[7:0], num[15:8], num[7:0]};
    endfunction

    function automatic void add_data(ref logic [7:0] f [$], input int words);
        f.push_back(8'(2 * words));
        for (int i = 0; i < 2 * words; i++)
            f.push_back(8'($urandom));
    endfunction

    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            replies_seen++;
            if (reply_q.size() == 0)
            begin
                $error("unexpected response transaction tx_byte=%0h", tx_byte);
                errors++;
            end
            else
            begin
                e = reply_q.pop_front();
                if (tx_byte !== e.tx)
                begin
                    $error("tx_byte expected %0h actual %0h", e.tx, tx_byte);
                    errors++;
                end
                if (last !== e.lst)
                begin
                    $error("last expected %0b actual %0b", e.lst, last);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, status);
                    errors++;
                end
            end
        end
    end

    task automatic test_reads_and_writes();
        logic [7:0] f [$];
        build_request(f, FN_WRITE_HOLD, 16'd26, 16'hffff);
        send_frame(f);
        build_request(f, FN_WRITE_COIL, 16'd0, 16'hff00);
        send_frame(f);
        build_request(f, FN_WRITE_MULTI, 16'd0, 16'd5);
        add_data(f, 5);
        send_frame(f);
        build_request(f, FN_READ_HOLD, 16'd0, 16'd27);
        send_frame(f);
        load_input(6'd0, 16'hffff);
        load_input(6'd63, 16'h0000);
        load_input(6'd37, 16'ha55a);
        build_request(f, FN_READ_INPUT, 16'd37, 16'd27);
        send_frame(f);
    endtask

    task automatic test_status_cases();
        logic [7:0] f [$];
        f = {8'hff};
        send_frame(f);
        build_request(f, 8'hff, 16'd0, 16'd1);
        f = f[0:7];
        send_frame(f);
        build_request(f, FN_READ_HOLD, 16'd0, 16'd1);
        f = f[0:9];
        send_frame(f);
        build_request(f, FN_READ_HOLD, 16'd0, 16'd28);
        send_frame(f);
        build_request(f, FN_WRITE_HOLD, 16'd64, 16'd5);
        send_frame(f);
        build_request(f, FN_WRITE_MULTI, 16'd2, 16'd3);
        add_data(f, 1);
        send_frame(f);
    endtask

    task automatic test_overflow_and_loads();
        logic [7:0] f [$];
        @(negedge clk);
        in_valid <= 1'b0;
        wait (reply_q.size() == 0);
        build_request(f, FN_READ_HOLD, 16'd1, 16'd3);
        while (f.size() < FRAME_LIMIT + 2)
            f.push_back(8'($urandom));
        for (int i = 0; i < 5; i++)
            send_item(1'b0, f[i], 1'b0, 6'($urandom), 16'($urandom));
        load_input(6'd5, 16'h1234);
        for (int i = 5; i < f.size(); i++)
            send_item(1'b0, f[i], i == f.size() - 1, 6'($urandom), 16'($urandom));
        frames_sent++;
        build_request(f, FN_READ_INPUT, 16'd0, 16'd8);
        send_frame(f);
    endtask

    task automatic random_traffic(int budget);
        logic [7:0] f [$];
        logic [7:0] fn;
        int pick;
        int num;
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                load_input(6'($urandom), 16'($urandom));
            else if (pick < 22)
            begin
                f.delete();
                repeat ($urandom_range(1, 16))
                    f.push_back(8'($urandom));
                send_frame(f);
            end
            else
            begin
                case ($urandom_range(4))
                    0: fn = FN_READ_HOLD;
                    1: fn = FN_READ_INPUT;
                    2: fn = FN_WRITE_COIL;
                    3: fn = FN_WRITE_HOLD;
                    default: fn = FN_WRITE_MULTI;
                endcase
                num = (fn == FN_WRITE_COIL || fn == FN_WRITE_HOLD) ? $urandom
                                                                    : $urandom_range(1, 6);
                build_request(f, fn, 16'($urandom_range(0, 60)), 16'(num));
                if (fn == FN_WRITE_MULTI)
                    add_data(f, num);
                if (pick < 27)
                    f = f[0:$urandom_range(0, f.size() - 1)];
                send_frame(f);
            end
        end
    endtask

    initial
    begin
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        frames_sent = 0;
        items_sent = 0;
        replies_seen = 0;
        frame_len = 0;
        for (int i = 0; i < REG_COUNT_DEF; i++)
        begin
            hold_regs[i] = 16'd0;
            input_regs[i] = 16'd0;
            coil_regs[i] = 16'd0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reads_and_writes();
        recv_stall = 64;
        test_status_cases();
        send_idle = 64;
        recv_stall = 0;
        test_overflow_and_loads();
        send_idle = 34;
        recv_stall = 34;
        random_traffic(20);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (reply_q.size() == 0);
        repeat (200) @(posedge clk);
        $display("sent %0d frames in %0d input transactions, checked %0d response transactions",
                 frames_sent, items_sent, replies_seen);
        if (errors == 0 && reply_q.size() == 0)
            $display("PASS modbus_tcp_register_server");
        else
            $display("FAIL modbus_tcp_register_server");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("FAIL modbus_tcp_register_server");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mtrs_pkg.sv
rtl/core/modbus_tcp_register_server.sv
tb/sv/testbench.sv
